// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the reassembler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHECK_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CHECK_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/h264fua_pkg.sv =====
// ----------------------------------------------------------------------------
// h264fua_pkg
// Types and constants of the H.264 FU-A reassembler.
// ----------------------------------------------------------------------------
package h264fua_pkg;

   localparam int DEF_FRAME_BYTES  = 2048;
   localparam int DEF_PACKET_BYTES = 2048;

   localparam logic [6:0] VIDEO_PT_RESET = 7'd96;
   localparam logic [7:0] NAL_TYPE_MASK  = 8'h1f;
   localparam logic [7:0] NAL_TYPE_FU_A  = 8'h1c;
   localparam logic [7:0] NAL_TYPE_IDR   = 8'h05;
   localparam logic [7:0] FU_FLAG_MASK   = 8'he0;
   localparam logic [7:0] FU_START       = 8'h80;
   localparam logic [7:0] FU_END         = 8'h40;
   localparam logic [11:0] SEED_LENGTH   = 12'd30;
   localparam int HDR_BYTES = 5;

   typedef enum logic [2:0] {
      EV_FRAME   = 3'd0,
      EV_MARKER  = 3'd1,
      EV_LOSS    = 3'd2,
      EV_FORMAT  = 3'd3,
      EV_OVERFLW = 3'd4,
      EV_IGNORED = 3'd5,
      EV_READ    = 3'd6
   } event_type;

   typedef enum logic {
      OP_PACKET = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef struct packed {
      event_type   code;
      logic [11:0] length;
      logic [7:0]  rbyte;
   } result_type;

endpackage

// ===== hdl/h264fua_ram.sv =====
// ----------------------------------------------------------------------------
// h264fua_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module h264fua_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/h264_fu_a_reassembler_top.sv =====
// A result item is registered in stage one, then written into the result queue, which offers it.
// Throughput: one item per cycle while req_ready is high; stores take one write per payload byte.
// Two-entry result queue lets input continue while a result waits.
// Reset: synchronous; clears sequence, position, bank, counters and queue.
// Frame and marker stores are not cleared; header bytes live in registers.
// ----------------------------------------------------------------------------
// h264_fu_a_reassembler_top
// Rebuilds H.264 NAL units from RTP FU-A fragments into a ping-pong store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module h264_fu_a_reassembler_top
   import h264fua_pkg::*;
#(
   parameter int FRAME_BYTES  = DEF_FRAME_BYTES,
   parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_last,
   input  logic [11:0] req_packet_length,
   input  logic [15:0] req_seq_number,
   input  logic        req_marker_bit,
   input  logic [6:0]  req_payload_kind,
   input  logic        req_read_region,
   input  logic [10:0] req_read_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_code,
   output logic [11:0] rsp_result_length,
   output logic [7:0]  rsp_read_byte
);

   localparam int FW    = $clog2(FRAME_BYTES);
   localparam int MW    = $clog2(PACKET_BYTES);
   localparam int POS_W = $clog2(FRAME_BYTES + 1);
   localparam int OFS_W = $clog2(FRAME_BYTES + 4096) + 1;
   localparam logic [OFS_W-1:0] FRAME_LIM = OFS_W'(FRAME_BYTES);
   localparam logic [OFS_W-1:0] PKT_LIM   = OFS_W'(PACKET_BYTES);

   // Architectural state
   logic [6:0]       vpt_ff;
   logic [15:0]      lseq_ff, lseq_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [10:0]      bcnt_ff, bcnt_in;
   logic             bank_ff, bank_in;
   logic [7:0]       head_ff [6];
   logic [7:0]       head_in [6];
   logic [7:0]       tail_ff [6];
   logic [7:0]       tail_in [6];
   logic [7:0]       shadow_ff [2][HDR_BYTES];

   // Stage one and result queue
   logic        s1_valid_ff, s1_valid_in;
   result_type  s1_res_ff, s1_res_in;
   logic        s1_zero_ff, s1_zero_in;
   logic        s1_mark_ff, s1_mark_in;
   logic        s1_shad_ff, s1_shad_in;
   logic [7:0]  s1_sval_ff, s1_sval_in;
   result_type  q_ff [2];
   logic        q_wptr_ff, q_rptr_ff;
   logic [1:0]  q_cnt_ff;

   logic accept, pop, is_pkt, video, in_len;
   logic [OFS_W-1:0] idx_x, len_x, base_x, ofs_x, next_x;
   logic fu_ok, fstart, fend, seed, gap, drop;
   logic [15:0] ls_cand;
   logic fr_we, mk_we;
   logic [FW:0] fr_waddr, fr_raddr;
   logic [MW-1:0] mk_waddr, mk_raddr;
   logic [7:0] fr_rdata, mk_rdata, push_byte;
   logic [31:0] raddr_ext;
   logic hdr_we, spec_shadow;
   logic [7:0] hdr_byte;

   assign pop      = rsp_valid && rsp_ready;
   assign req_ready = ({1'b0, q_cnt_ff} + {2'b00, s1_valid_ff} - {2'b00, pop}) <= 3'd1;
   assign accept   = req_valid && req_ready;
   assign is_pkt   = accept && (req_operation == OP_PACKET);
   assign video    = (req_payload_kind == vpt_ff);
   assign idx_x    = OFS_W'(bcnt_ff);
   assign len_x    = OFS_W'(req_packet_length);
   assign in_len   = idx_x < len_x;
   assign raddr_ext = 32'(req_read_address);

   // Update head and tail byte windows
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         head_in[i] = (bcnt_ff == 11'd0) ? 8'd0 : head_ff[i];
      end
      if (bcnt_ff < 11'd6) begin
         head_in[bcnt_ff[2:0]] = req_data_byte;
      end
      for (int i = 0; i < 5; i++) begin
         tail_in[i] = tail_ff[i + 1];
      end
      tail_in[5] = req_data_byte;
   end

   assign fu_ok  = head_in[0] == 8'd0 && head_in[1] == 8'd0 && head_in[2] == 8'd0 &&
                   head_in[3] == 8'd1 && (head_in[4] & NAL_TYPE_MASK) == NAL_TYPE_FU_A;
   assign fstart = (head_in[5] & FU_FLAG_MASK) == FU_START;
   assign fend   = (head_in[5] & FU_FLAG_MASK) == FU_END;
   assign base_x = fstart ? OFS_W'(HDR_BYTES) : OFS_W'(pos_ff);
   assign ofs_x  = base_x + idx_x - OFS_W'(6);

   // Speculative store writes
   assign fr_we = is_pkt && video && in_len && !req_marker_bit && bcnt_ff >= 11'd6 &&
                  fu_ok && ofs_x < FRAME_LIM;
   assign mk_we = is_pkt && video && in_len && req_marker_bit && idx_x < PKT_LIM;
   assign fr_waddr = {bank_ff, ofs_x[FW-1:0]};
   assign mk_waddr = MW'(bcnt_ff);
   assign fr_raddr = {~bank_ff, raddr_ext[FW-1:0]};
   assign mk_raddr = raddr_ext[MW-1:0];
   assign spec_shadow = fr_we && ofs_x < OFS_W'(HDR_BYTES);

   // Sequence check
   assign seed = req_packet_length == SEED_LENGTH && tail_in[0] == 8'd0 &&
                 tail_in[1] == 8'd1 && tail_in[2] == 8'd0 && tail_in[3] == 8'd1 &&
                 tail_in[4] == 8'd0 && tail_in[5] == 8'd1;
   assign ls_cand = seed ? req_seq_number - 16'd1 : lseq_ff;
   assign gap  = (ls_cand + 16'd1) != req_seq_number && ls_cand != 16'd0;
   assign drop = gap && (req_marker_bit ? (head_in[4] & NAL_TYPE_MASK) != NAL_TYPE_IDR :
                 ((head_in[5] & NAL_TYPE_MASK) != NAL_TYPE_IDR || !fstart));
   assign next_x = fstart ? len_x - OFS_W'(1) : OFS_W'(pos_ff) + len_x - OFS_W'(6);
   assign hdr_byte = (head_in[4] & FU_FLAG_MASK) | (head_in[5] & NAL_TYPE_MASK);

   // Decide at the last byte of a packet; serve reads
   always_comb begin
      lseq_in = lseq_ff;
      pos_in  = pos_ff;
      bcnt_in = bcnt_ff;
      bank_in = bank_ff;
      hdr_we  = 1'b0;
      s1_valid_in = 1'b0;
      s1_res_in   = '{code: EV_IGNORED, length: 12'd0, rbyte: 8'd0};
      s1_zero_in  = 1'b1;
      s1_mark_in  = 1'b0;
      s1_shad_in  = 1'b0;
      s1_sval_in  = shadow_ff[~bank_ff][raddr_ext[2:0]];
      if (accept && req_operation == OP_READ) begin
         s1_valid_in = 1'b1;
         s1_res_in.code = EV_READ;
         s1_mark_in = req_read_region;
         if (req_read_region) begin
            s1_zero_in = raddr_ext >= 32'(PACKET_BYTES);
         end else begin
            s1_zero_in = raddr_ext >= 32'(FRAME_BYTES);
            s1_shad_in = raddr_ext < 32'(HDR_BYTES);
         end
      end else if (is_pkt && !req_byte_last) begin
         bcnt_in = bcnt_ff + 11'd1;
      end else if (is_pkt) begin
         bcnt_in = 11'd0;
         s1_valid_in = 1'b1;
         priority if (!video) begin
            s1_res_in.code = EV_IGNORED;
         end else if (drop) begin
            lseq_in = ls_cand;
            pos_in  = '0;
            s1_res_in.code = EV_LOSS;
         end else if (req_marker_bit) begin
            lseq_in = req_seq_number;
            if (len_x > PKT_LIM) begin
               s1_res_in.code = EV_OVERFLW;
            end else begin
               s1_res_in.code = EV_MARKER;
               s1_res_in.length = req_packet_length;
            end
         end else if (req_packet_length <= 12'd6 || !fu_ok) begin
            lseq_in = req_seq_number;
            s1_res_in.code = EV_FORMAT;
         end else if (next_x > FRAME_LIM) begin
            lseq_in = req_seq_number;
            pos_in  = '0;
            s1_res_in.code = EV_OVERFLW;
         end else if (fstart) begin
            lseq_in = req_seq_number;
            pos_in  = POS_W'(next_x);
            hdr_we  = 1'b1;
            s1_valid_in = 1'b0;
         end else if (fend) begin
            lseq_in = req_seq_number;
            pos_in  = '0;
            bank_in = ~bank_ff;
            s1_res_in.code = EV_FRAME;
            s1_res_in.length = next_x[11:0];
         end else begin
            lseq_in = req_seq_number;
            pos_in  = POS_W'(next_x);
            s1_valid_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vpt_ff  <= VIDEO_PT_RESET;
         lseq_ff <= '0;
         pos_ff  <= '0;
         bcnt_ff <= '0;
         bank_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            vpt_ff <= csr_wr_data;
         end
         lseq_ff <= lseq_in;
         pos_ff  <= pos_in;
         bcnt_ff <= bcnt_in;
         bank_ff <= bank_in;
         s1_valid_ff <= s1_valid_in;
         if (is_pkt) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
      end
   end

   // Stage one payload and header shadow
   always_ff @(posedge clock) begin
      s1_res_ff  <= s1_res_in;
      s1_zero_ff <= s1_zero_in;
      s1_mark_ff <= s1_mark_in;
      s1_shad_ff <= s1_shad_in;
      s1_sval_ff <= s1_sval_in;
      if (spec_shadow) begin
         shadow_ff[bank_ff][ofs_x[2:0]] <= req_data_byte;
      end
      if (hdr_we) begin
         shadow_ff[bank_ff][0] <= 8'd0;
         shadow_ff[bank_ff][1] <= 8'd0;
         shadow_ff[bank_ff][2] <= 8'd0;
         shadow_ff[bank_ff][3] <= 8'd1;
         shadow_ff[bank_ff][4] <= hdr_byte;
      end
   end

   h264fua_ram #(.WIDTH(8), .DEPTH(2 ** (FW + 1))) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (req_data_byte),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata)
   );

   h264fua_ram #(.WIDTH(8), .DEPTH(2 ** MW)) u_marker_ram (
      .clock   (clock),
      .wr_en   (mk_we),
      .wr_addr (mk_waddr),
      .wr_data (req_data_byte),
      .rd_addr (mk_raddr),
      .rd_data (mk_rdata)
   );

   // Select the fetched byte
   always_comb begin
      priority if (s1_res_ff.code != EV_READ || s1_zero_ff) begin
         push_byte = 8'd0;
      end else if (s1_mark_ff) begin
         push_byte = mk_rdata;
      end else if (s1_shad_ff) begin
         push_byte = s1_sval_ff;
      end else begin
         push_byte = fr_rdata;
      end
   end

   // Result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wptr_ff <= 1'b0;
         q_rptr_ff <= 1'b0;
         q_cnt_ff  <= '0;
      end else begin
         if (s1_valid_ff) begin
            q_wptr_ff <= ~q_wptr_ff;
         end
         if (pop) begin
            q_rptr_ff <= ~q_rptr_ff;
         end
         q_cnt_ff <= q_cnt_ff + {1'b0, s1_valid_ff} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_ff[q_wptr_ff] <= '{code: s1_res_ff.code, length: s1_res_ff.length,
                              rbyte: push_byte};
      end
   end

   assign rsp_valid         = q_cnt_ff != 2'd0;
   assign rsp_event_code    = q_ff[q_rptr_ff].code;
   assign rsp_result_length = q_ff[q_rptr_ff].length;
   assign rsp_read_byte     = q_ff[q_rptr_ff].rbyte;

   `CHECK_NEVER(a_q_over, clock, reset, q_cnt_ff == 2'd3, "result queue count out of range")
   `CHECK_PROP(a_q_room, clock, reset, s1_valid_ff |-> q_cnt_ff != 2'd2 || pop, "queue overrun")
   `CHECK_PROP(a_read_len, clock, reset, (rsp_valid && rsp_event_code == EV_READ) |-> rsp_result_length == 12'd0, "read result carries a length")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the H.264 FU-A reassembler.
// Sends RTP payloads byte by byte: seed packets, FU-A start, middle and end
// fragments, marker packets, sequence gaps, foreign payload types, broken
// headers, length mismatches and oversize lengths, plus reads of stored bytes.
// A scoreboard class predicts each result and checks the result channel.
// ----------------------------------------------------------------------------
module tb;
   import h264fua_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      op_type     op;
      bit [7:0]   data;
      bit         last;
      bit [11:0]  len;
      bit [15:0]  seq;
      bit         mark;
      bit [6:0]   kind;
      bit         region;
      bit [10:0]  addr;
   } req_item_type;

   // Tracks the reassembly state and the queue of pending results
   class frame_scoreboard;
      bit [6:0]   video_pt;
      bit [15:0]  last_seq;
      int unsigned pos;
      bit [10:0]  byte_idx;
      bit         bank;
      bit [7:0]   head[6];
      bit [7:0]   tail[6];
      bit [7:0]   frame_mem[4096];
      bit         frame_set[4096];
      bit [7:0]   marker_mem[2048];
      bit         marker_set[2048];
      result_type expected_q[$];
      int         errors;

      function void clear();
         video_pt = VIDEO_PT_RESET;
         last_seq = 0;
         pos = 0;
         byte_idx = 0;
         bank = 0;
         foreach (head[i]) begin
            head[i] = 0;
            tail[i] = 0;
         end
         expected_q.delete();
         errors = 0;
      endfunction

      function bit fua_ok();
         return head[0] == 0 && head[1] == 0 && head[2] == 0 && head[3] == 1 &&
                (head[4] & NAL_TYPE_MASK) == NAL_TYPE_FU_A;
      endfunction

      function void put_frame(int unsigned off, bit [7:0] v);
         if (off < DEF_FRAME_BYTES) begin
            frame_mem[bank * DEF_FRAME_BYTES + off] = v;
            frame_set[bank * DEF_FRAME_BYTES + off] = 1;
         end
      endfunction

      function void push_event(event_type c, bit [11:0] l, bit [7:0] b);
         result_type r;
         r.code = c;
         r.length = l;
         r.rbyte = b;
         expected_q.push_back(r);
      endfunction

      // Find a written byte in the given region, starting at a random offset
      function bit find_stored(bit region, output bit [10:0] a);
         int s, j, k;
         s = $urandom_range(0, 2047);
         a = 0;
         for (k = 0; k < 2048; k++) begin
            j = (s + k) % 2048;
            if (region ? marker_set[j] : frame_set[(bank ^ 1) * DEF_FRAME_BYTES + j]) begin
               a = 11'(j);
               return 1;
            end
         end
         return 0;
      endfunction

      // Advance the state by one accepted item
      function void note_item(req_item_type it);
         int unsigned idx, nxt, base;
         bit video, drop, fstart;
         bit [7:0] v;
         bit [15:0] succ;
         if (it.op == OP_READ) begin
            if (it.region == 0)
               v = frame_mem[(bank ^ 1) * DEF_FRAME_BYTES + it.addr];
            else
               v = marker_mem[it.addr];
            push_event(EV_READ, 12'd0, v);
            return;
         end
         idx = byte_idx;
         video = (it.kind == video_pt);
         if (idx == 0)
            foreach (head[i]) head[i] = 0;
         if (idx < 6)
            head[idx] = it.data;
         for (int i = 0; i < 5; i++)
            tail[i] = tail[i + 1];
         tail[5] = it.data;
         fstart = (head[5] & FU_FLAG_MASK) == FU_START;

         // store payload bytes as they pass
         if (video && idx < it.len) begin
            if (it.mark) begin
               marker_mem[idx] = it.data;
               marker_set[idx] = 1;
            end else if (idx >= 6 && fua_ok()) begin
               base = fstart ? HDR_BYTES : pos;
               put_frame(base + idx - 6, it.data);
            end
         end
         if (!it.last) begin
            byte_idx = byte_idx + 11'd1;
            return;
         end
         byte_idx = 0;
         if (!video) begin
            push_event(EV_IGNORED, 12'd0, 8'd0);
            return;
         end

         // seed packet sets the expected sequence
         if (it.len == SEED_LENGTH && tail[0] == 0 && tail[1] == 1 && tail[2] == 0 &&
             tail[3] == 1 && tail[4] == 0 && tail[5] == 1)
            last_seq = it.seq - 16'd1;

         // on a gap keep only keyframe material
         succ = last_seq + 16'd1;
         if (succ != it.seq && last_seq != 0) begin
            if (it.mark)
               drop = (head[4] & NAL_TYPE_MASK) != NAL_TYPE_IDR;
            else
               drop = (head[5] & NAL_TYPE_MASK) != NAL_TYPE_IDR || !fstart;
            if (drop) begin
               pos = 0;
               push_event(EV_LOSS, 12'd0, 8'd0);
               return;
            end
         end
         last_seq = it.seq;

         if (it.mark) begin
            if (it.len > DEF_PACKET_BYTES)
               push_event(EV_OVERFLW, 12'd0, 8'd0);
            else
               push_event(EV_MARKER, it.len, 8'd0);
            return;
         end
         if (it.len <= 6 || !fua_ok()) begin
            push_event(EV_FORMAT, 12'd0, 8'd0);
            return;
         end
         if (fstart) begin
            nxt = it.len - 1;
            if (nxt > DEF_FRAME_BYTES) begin
               pos = 0;
               push_event(EV_OVERFLW, 12'd0, 8'd0);
               return;
            end
            put_frame(0, 8'h00);
            put_frame(1, 8'h00);
            put_frame(2, 8'h00);
            put_frame(3, 8'h01);
            put_frame(4, (head[4] & FU_FLAG_MASK) | (head[5] & NAL_TYPE_MASK));
            pos = nxt;
            return;
         end
         nxt = pos + it.len - 6;
         if (nxt > DEF_FRAME_BYTES) begin
            pos = 0;
            push_event(EV_OVERFLW, 12'd0, 8'd0);
            return;
         end
         if ((head[5] & FU_FLAG_MASK) == FU_END) begin
            bank ^= 1;
            pos = 0;
            push_event(EV_FRAME, 12'(nxt), 8'd0);
            return;
         end
         pos = nxt;
      endfunction

      // Compare one result with the oldest expectation
      function void check_result(result_type got);
         result_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result code %0d len %0d byte %0d", $realtime,
                        got.code, got.length, got.rbyte);
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.code != exp_r.code || got.length != exp_r.length ||
             got.rbyte != exp_r.rbyte) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch exp code %0d len %0d byte %0d, got %0d %0d %0d",
                        $realtime, exp_r.code, exp_r.length, exp_r.rbyte,
                        got.code, got.length, got.rbyte);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [7:0]  req_data_byte;
   logic        req_byte_last;
   logic [11:0] req_packet_length;
   logic [15:0] req_seq_number;
   logic        req_marker_bit;
   logic [6:0]  req_payload_kind;
   logic        req_read_region;
   logic [10:0] req_read_address;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_code;
   logic [11:0] rsp_result_length;
   logic [7:0]  rsp_read_byte;

   frame_scoreboard sb;
   bit        req_took;
   bit        quiet_req;
   bit        quiet_rsp;
   int        rsp_hold;
   int        idle_cycles;
   int        items_sent;
   bit [6:0]  cur_pt;
   bit [15:0] seq_cur;
   bit [7:0]  pkt[$];

   h264_fu_a_reassembler_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_data_byte     (req_data_byte),
      .req_byte_last     (req_byte_last),
      .req_packet_length (req_packet_length),
      .req_seq_number    (req_seq_number),
      .req_marker_bit    (req_marker_bit),
      .req_payload_kind  (req_payload_kind),
      .req_read_region   (req_read_region),
      .req_read_address  (req_read_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_code    (rsp_event_code),
      .rsp_result_length (rsp_result_length),
      .rsp_read_byte     (rsp_read_byte)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Sample both channels and run the watchdog
   always @(posedge clock) begin
      req_item_type it;
      result_type got;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            it.op = op_type'(req_operation);
            it.data = req_data_byte;
            it.last = req_byte_last;
            it.len = req_packet_length;
            it.seq = req_seq_number;
            it.mark = req_marker_bit;
            it.kind = req_payload_kind;
            it.region = req_read_region;
            it.addr = req_read_address;
            sb.note_item(it);
            req_took = 1;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            got.code = event_type'(rsp_event_code);
            got.length = rsp_result_length;
            got.rbyte = rsp_read_byte;
            sb.check_result(got);
            rsp_hold = quiet_rsp ? 0 : $urandom_range(0, 11);
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Stall the result channel for the drawn number of cycles
   always @(negedge clock) begin
      if (reset)
         rsp_ready = 0;
      else if (rsp_hold > 0) begin
         rsp_ready = 0;
         rsp_hold--;
      end else
         rsp_ready = 1;
   end

   // Offer one item after a random gap, hold it until accepted, then drop valid
   task send_item(req_item_type it);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_operation = it.op;
      req_data_byte = it.data;
      req_byte_last = it.last;
      req_packet_length = it.len;
      req_seq_number = it.seq;
      req_marker_bit = it.mark;
      req_payload_kind = it.kind;
      req_read_region = it.region;
      req_read_address = it.addr;
      req_valid = 1;
      req_took = 0;
      do @(negedge clock); while (!req_took);
      req_valid = 0;
      items_sent++;
   endtask

   // Send the bytes in pkt as one packet
   task issue_packet(bit [11:0] len, bit [15:0] seq, bit mark, bit [6:0] kind);
      req_item_type it;
      foreach (pkt[i]) begin
         it.op = OP_PACKET;
         it.data = pkt[i];
         it.last = (i == pkt.size() - 1);
         it.len = len;
         it.seq = seq;
         it.mark = mark;
         it.kind = kind;
         it.region = $urandom_range(0, 1);
         it.addr = $urandom_range(0, 2047);
         send_item(it);
      end
   endtask

   // Read back bytes that were stored before
   task issue_reads(int count);
      req_item_type it;
      bit [10:0] a;
      repeat (count) begin
         it.op = OP_READ;
         it.region = $urandom_range(0, 1);
         if (!sb.find_stored(it.region, a)) begin
            it.region = ~it.region;
            if (!sb.find_stored(it.region, a))
               continue;
         end
         it.addr = a;
         it.data = $urandom;
         it.last = $urandom;
         it.len = $urandom;
         it.seq = $urandom;
         it.mark = $urandom;
         it.kind = $urandom;
         send_item(it);
      end
   endtask

   task set_video_pt(bit [6:0] v);
      while (sb.expected_q.size() != 0) @(negedge clock);
      req_valid = 0;
      repeat (6) @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      sb.video_pt = v;
      cur_pt = v;
   endtask

   function void build_fua(bit [7:0] flags, bit [7:0] nal, int n);
      pkt.delete();
      pkt = '{8'h00, 8'h00, 8'h00, 8'h01};
      pkt.push_back((8'($urandom) & FU_FLAG_MASK) | NAL_TYPE_FU_A);
      pkt.push_back(flags | (nal & NAL_TYPE_MASK));
      repeat (n) pkt.push_back($urandom);
   endfunction

   function void build_marker(bit [7:0] nal, int n);
      pkt.delete();
      pkt = '{8'h00, 8'h00, 8'h00, 8'h01};
      pkt.push_back((8'($urandom) & FU_FLAG_MASK) | (nal & NAL_TYPE_MASK));
      repeat (n) pkt.push_back($urandom);
   endfunction

   function void build_seed();
      pkt.delete();
      repeat (24) pkt.push_back($urandom);
      pkt.push_back(0); pkt.push_back(1); pkt.push_back(0);
      pkt.push_back(1); pkt.push_back(0); pkt.push_back(1);
   endfunction

   function bit [15:0] next_seq();
      if ($urandom_range(0, 99) < 6)
         seq_cur += 16'($urandom_range(2, 40));
      else
         seq_cur++;
      return seq_cur;
   endfunction

   // Mostly the true length; sometimes short, long or oversize
   function bit [11:0] pick_len(int n);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return $urandom_range(2049, 4095);
      if (r < 8)
         return (n > 3) ? n - $urandom_range(1, 3) : n + 1;
      if (r < 10)
         return n + $urandom_range(1, 5);
      return n;
   endfunction

   function int pick_size();
      return ($urandom_range(0, 99) < 3) ? $urandom_range(300, 900) : $urandom_range(1, 24);
   endfunction

   // Send pkt with random damage: wrong type, broken header, odd length
   task send_pkt(bit mark);
      bit [6:0] kind;
      kind = cur_pt;
      if ($urandom_range(0, 99) < 3)
         kind = cur_pt ^ 7'($urandom_range(1, 127));
      if ($urandom_range(0, 99) < 4)
         pkt[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
      issue_packet(pick_len(pkt.size()), next_seq(), mark, kind);
   endtask

   task random_unit();
      bit [7:0] nal, mid;
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         build_marker(($urandom_range(0, 1)) ? NAL_TYPE_IDR : 8'($urandom), pick_size());
         send_pkt(1);
      end else if (r < 14) begin
         build_seed();
         issue_packet(SEED_LENGTH, next_seq(), 0, cur_pt);
      end else if (r < 18) begin
         pkt.delete();
         repeat ($urandom_range(1, 10)) pkt.push_back($urandom);
         issue_packet(pkt.size(), $urandom, $urandom, $urandom);
      end else begin
         nal = ($urandom_range(0, 99) < 60) ? NAL_TYPE_IDR : 8'($urandom);
         build_fua(FU_START, nal, pick_size());
         send_pkt(0);
         repeat ($urandom_range(0, 3)) begin
            mid = 8'($urandom) & FU_FLAG_MASK;
            if (mid == FU_START || mid == FU_END)
               mid = 8'h00;
            build_fua(mid, nal, pick_size());
            send_pkt(0);
         end
         build_fua(FU_END, nal, pick_size());
         send_pkt(0);
      end
      issue_reads($urandom_range(0, 3));
   endtask

   initial begin
      bit [6:0] pts[4];
      sb = new();
      sb.clear();
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = 0;
      req_valid = 0;
      req_operation = 0;
      req_data_byte = 0;
      req_byte_last = 0;
      req_packet_length = 0;
      req_seq_number = 0;
      req_marker_bit = 0;
      req_payload_kind = 0;
      req_read_region = 0;
      req_read_address = 0;
      rsp_ready = 0;
      rsp_hold = 0;
      idle_cycles = 0;
      items_sent = 0;
      quiet_req = 0;
      quiet_rsp = 0;
      cur_pt = VIDEO_PT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: seed, a full unit across the sequence wrap, read back
      seq_cur = 16'hfffe;
      build_seed();
      issue_packet(SEED_LENGTH, seq_cur, 0, cur_pt);
      build_fua(FU_START, NAL_TYPE_IDR, 3);
      issue_packet(9, ++seq_cur, 0, cur_pt);
      build_fua(8'h00, NAL_TYPE_IDR, 2);
      issue_packet(8, ++seq_cur, 0, cur_pt);
      build_fua(FU_END, NAL_TYPE_IDR, 4);
      issue_packet(10, ++seq_cur, 0, cur_pt);
      issue_reads(3);
      // marker packet, then gaps that drop and that survive
      build_marker(8'h01, 2);
      issue_packet(7, ++seq_cur, 1, cur_pt);
      build_marker(8'h01, 1);
      issue_packet(6, seq_cur + 16'd6, 1, cur_pt);
      build_fua(FU_START, NAL_TYPE_IDR, 1);
      seq_cur += 16'd20;
      issue_packet(7, seq_cur, 0, cur_pt);
      // foreign type, short packet, bad prefix, oversize lengths
      pkt = '{8'hff};
      issue_packet(1, ++seq_cur, 0, cur_pt ^ 7'h01);
      pkt = '{8'h00, 8'h00, 8'h01};
      issue_packet(3, ++seq_cur, 0, cur_pt);
      build_fua(FU_END, NAL_TYPE_IDR, 1);
      pkt[3] = 8'h02;
      issue_packet(7, ++seq_cur, 0, cur_pt);
      build_fua(FU_START, NAL_TYPE_IDR, 1);
      issue_packet(12'hfff, ++seq_cur, 0, cur_pt);
      build_marker(NAL_TYPE_IDR, 0);
      issue_packet(12'hfff, ++seq_cur, 1, cur_pt);
      issue_reads(2);

      // Random phases, each under its own payload type
      pts[0] = 7'd127;
      pts[1] = 7'd0;
      pts[2] = $urandom_range(1, 126);
      pts[3] = VIDEO_PT_RESET;
      foreach (pts[p]) begin
         set_video_pt(pts[p]);
         quiet_req = (p == 1);
         quiet_rsp = (p == 2);
         while (items_sent < 60 + (p + 1) * 200)
            random_unit();
      end
      @(negedge clock);
      req_valid = 0;

      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== h264_fu_a_reassembler_top.f =====
+incdir+hdl
hdl/h264fua_pkg.sv
hdl/h264fua_ram.sv
hdl/h264_fu_a_reassembler_top.sv
sim/tb.sv
